[hdl/tkhr_pkg.sv]
// shared types, key codes and constants for the touch keypad hold/repeat decoder
`default_nettype none

package tkhr_pkg;

    localparam int unsigned CHANNELS   = 16;
    localparam int unsigned KEY_COUNT  = 13;
    localparam int unsigned HOLD_W     = 9;
    localparam int unsigned QUIET_W    = 5;
    localparam int unsigned PHASE_W    = 7;
    localparam int unsigned KEY_W      = 4;
    localparam int unsigned POST_W     = 5;
    localparam int unsigned CFG_DATA_W = 9;
    localparam int unsigned CFG_IDX_W  = 2;

    // key codes
    localparam logic [KEY_W-1:0] KEY_BLANK  = 4'd0;
    localparam logic [KEY_W-1:0] KEY_TWO    = 4'd3;
    localparam logic [KEY_W-1:0] KEY_DIGIT8 = 4'd9;
    localparam logic [KEY_W-1:0] KEY_POUND  = 4'd11;
    localparam logic [KEY_W-1:0] KEY_ASTER  = 4'd12;
    localparam logic [KEY_W-1:0] KEY_CLOSE  = 4'd13;

    // posted codes
    localparam logic [POST_W-1:0] POST_NONE       = 5'd0;
    localparam logic [POST_W-1:0] POST_POUND      = 5'd11;
    localparam logic [POST_W-1:0] POST_CLOSE      = 5'd13;
    localparam logic [POST_W-1:0] POST_ASTER_HOLD = 5'd14;
    localparam logic [POST_W-1:0] POST_POUND_HOLD = 5'd15;
    localparam logic [POST_W-1:0] POST_TWO_HOLD   = 5'd16;
    localparam logic [POST_W-1:0] POST_EIGHT_HOLD = 5'd17;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_CAP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAKE_QUIET = 2'd2;

    localparam logic [HOLD_W-1:0]  HOLD_DELAY_RESET = 9'd128;
    localparam logic [HOLD_W-1:0]  HOLD_CAP_RESET   = 9'd320;
    localparam logic [QUIET_W-1:0] WAKE_QUIET_RESET = 5'd16;

    typedef struct packed {
        logic [CHANNELS-1:0] key_bits;
        logic                wake_start;
    } scan_t;

    typedef struct packed {
        logic [POST_W-1:0] posted_key;
        logic [KEY_W-1:0]  current_key;
    } post_t;

    typedef struct packed {
        logic [HOLD_W-1:0]  hold_delay;
        logic [HOLD_W-1:0]  hold_cap;
        logic [QUIET_W-1:0] wake_quiet_ticks;
    } cfg_t;

    // touch channel wired to each key code, 1..13
    function automatic logic [3:0] chan_of_key(input logic [KEY_W-1:0] code);
        logic [3:0] chan;
        case (code)
            4'd1:    chan = 4'd0;
            4'd2:    chan = 4'd6;
            4'd3:    chan = 4'd7;
            4'd4:    chan = 4'd11;
            4'd5:    chan = 4'd5;
            4'd6:    chan = 4'd4;
            4'd7:    chan = 4'd10;
            4'd8:    chan = 4'd3;
            4'd9:    chan = 4'd2;
            4'd10:   chan = 4'd9;
            4'd11:   chan = 4'd8;
            4'd12:   chan = 4'd1;
            4'd13:   chan = 4'd12;
            default: chan = 4'd0;
        endcase
        return chan;
    endfunction

    function automatic logic key_down(input logic [CHANNELS-1:0] bits,
                                      input logic [KEY_W-1:0] code);
        logic down;
        if (code == KEY_BLANK || code > KEY_CLOSE)
            down = 1'b0;
        else
            down = bits[chan_of_key(code)];
        return down;
    endfunction

endpackage

`default_nettype wire

[hdl/touch_keypad_hold_repeat_decoder_top.sv]
// top level of the touch keypad decoder with hold auto-repeat
// usage:
//   scan channel: one beat per scan tick, 16 touch-channel bits plus wake_start
//   post channel: one beat back per scan beat, posted key code and current key
//   both channels are valid/ready; a beat moves when valid and ready are high
//   path: an accepted scan beat is held in the input register, then in the result
//     register, which drives post
//   throughput: one beat per cycle while post is taken; the input register and
//     the result register both advance together, so scan_ready stays high
//   stall: while post_ready is low the result holds; one more scan beat is
//     buffered in the input register, then scan_ready drops
//   reset: rst_n low clears last key, hold and phase counters, wake lock,
//     quiet counter and both valid flags; registers return to their defaults
//     (hold delay 128, hold cap 320, quiet ticks 16)
//   configuration: cfg_we writes cfg_data into register cfg_index;
//     index 0 hold delay, 1 hold cap, 2 wake quiet ticks, 3 ignored
//   write registers only while no beat is in flight
`default_nettype none

module touch_keypad_hold_repeat_decoder_top #(
    parameter logic [tkhr_pkg::HOLD_W-1:0]  HOLD_DELAY_INIT = tkhr_pkg::HOLD_DELAY_RESET,
    parameter logic [tkhr_pkg::HOLD_W-1:0]  HOLD_CAP_INIT   = tkhr_pkg::HOLD_CAP_RESET,
    parameter logic [tkhr_pkg::QUIET_W-1:0] WAKE_QUIET_INIT = tkhr_pkg::WAKE_QUIET_RESET
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              scan_valid,
    output logic                                   scan_ready,
    input  wire tkhr_pkg::scan_t                   scan,
    output logic                                   post_valid,
    input  wire logic                              post_ready,
    output tkhr_pkg::post_t                        post,
    input  wire logic                              cfg_we,
    input  wire logic [tkhr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tkhr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    tkhr_pkg::cfg_t  cfg_reg;
    tkhr_pkg::scan_t item;
    logic            item_valid;
    logic            take;

    // configuration registers, written when cfg_we is high, no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_delay       <= HOLD_DELAY_INIT;
            cfg_reg.hold_cap         <= HOLD_CAP_INIT;
            cfg_reg.wake_quiet_ticks <= WAKE_QUIET_INIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tkhr_pkg::CFG_HOLD_DELAY: cfg_reg.hold_delay <= cfg_data;
                tkhr_pkg::CFG_HOLD_CAP:   cfg_reg.hold_cap   <= cfg_data;
                tkhr_pkg::CFG_WAKE_QUIET:
                    cfg_reg.wake_quiet_ticks <= cfg_data[tkhr_pkg::QUIET_W-1:0];
                default: ;
            endcase
        end
    end

    // scan beat waits here for the decode stage
    tkhr_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_valid (scan_valid),
        .scan_ready (scan_ready),
        .scan       (scan),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // decode, state update and result register
    tkhr_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .cfg        (cfg_reg),
        .take       (take),
        .res_valid  (post_valid),
        .res_ready  (post_ready),
        .res        (post)
    );

    // current key is only ever blank or a real key code
    a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
        post_valid |-> post.current_key <= tkhr_pkg::KEY_CLOSE)
        else $error("current key out of range");

    // a plain key post always names the current key
    a_post_is_cur: assert property (@(posedge clk) disable iff (!rst_n)
        (post_valid && post.posted_key != tkhr_pkg::POST_NONE
            && post.posted_key <= tkhr_pkg::POST_CLOSE)
        |-> post.posted_key == tkhr_pkg::POST_W'(post.current_key))
        else $error("posted key differs from current key");

    // a pound hold code only comes with the pound key held
    a_hold_key: assert property (@(posedge clk) disable iff (!rst_n)
        (post_valid && post.posted_key == tkhr_pkg::POST_POUND_HOLD)
        |-> post.current_key == tkhr_pkg::KEY_POUND)
        else $error("pound hold without pound key");

    // with the result register empty, scan_ready is always high
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !post_valid |-> scan_ready)
        else $error("scan stalled with empty result register");

endmodule

`default_nettype wire

[hdl/tkhr_in_reg.sv]
// input register holding one scan beat ahead of the decode stage
`default_nettype none

module tkhr_in_reg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           scan_valid,
    output logic                scan_ready,
    input  wire tkhr_pkg::scan_t scan,
    input  wire logic           take,
    output logic                item_valid,
    output tkhr_pkg::scan_t     item
);

    logic            valid_reg;
    tkhr_pkg::scan_t data_reg;

    // refill in the same cycle the held beat moves on
    assign scan_ready = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (scan_ready)
        begin
            valid_reg <= scan_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_ready && scan_valid)
        begin
            data_reg <= scan;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

`default_nettype wire

[hdl/tkhr_core.sv]
// key select, hold counting, wake lock and the result register
`default_nettype none

module tkhr_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    input  wire tkhr_pkg::scan_t item,
    input  wire tkhr_pkg::cfg_t  cfg,
    output logic                 take,
    output logic                 res_valid,
    input  wire logic            res_ready,
    output tkhr_pkg::post_t      res
);

    logic [tkhr_pkg::KEY_W-1:0]   last_key_reg, last_key_next;
    logic [tkhr_pkg::HOLD_W-1:0]  hold_reg, hold_next;
    logic [tkhr_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic                         wake_lock_reg, wake_lock_next;
    logic [tkhr_pkg::QUIET_W-1:0] quiet_reg, quiet_next;
    logic                         res_valid_reg;
    tkhr_pkg::post_t              res_reg, res_next;

    logic [tkhr_pkg::KEY_W-1:0]   first_key;
    logic [tkhr_pkg::KEY_W-1:0]   cur;
    logic [tkhr_pkg::POST_W-1:0]  post;

    assign take = item_valid && (!res_valid_reg || res_ready);

    // lowest pressed key code
    always_comb
    begin
        first_key = tkhr_pkg::KEY_BLANK;
        for (int c = tkhr_pkg::KEY_COUNT; c >= 1; c--)
        begin
            if (tkhr_pkg::key_down(item.key_bits, tkhr_pkg::KEY_W'(c)))
                first_key = tkhr_pkg::KEY_W'(c);
        end
    end

    always_comb
    begin
        wake_lock_next = wake_lock_reg;
        quiet_next     = quiet_reg;
        last_key_next  = last_key_reg;
        hold_next      = hold_reg;
        phase_next     = phase_reg;
        post           = tkhr_pkg::POST_NONE;

        if (item.wake_start)
        begin
            wake_lock_next = 1'b1;
            quiet_next     = '0;
        end

        if (item.key_bits == '0)
        begin
            if (quiet_next < cfg.wake_quiet_ticks)
                quiet_next = quiet_next + 1'b1;
            else
                wake_lock_next = 1'b0;
        end

        // sticky on the previous key while it stays down
        if (tkhr_pkg::key_down(item.key_bits, last_key_reg))
            cur = last_key_reg;
        else
            cur = first_key;

        if (cur != tkhr_pkg::KEY_BLANK)
        begin
            if (cur != last_key_reg)
            begin
                post          = tkhr_pkg::POST_W'(cur);
                last_key_next = cur;
                hold_next     = '0;
            end
            else
            begin
                if (hold_reg < cfg.hold_cap)
                    hold_next = hold_reg + 1'b1;
                if (hold_next > cfg.hold_delay)
                begin
                    if (phase_reg[1:0] == 2'b00)
                    begin
                        case (cur)
                            tkhr_pkg::KEY_ASTER:  post = tkhr_pkg::POST_ASTER_HOLD;
                            tkhr_pkg::KEY_POUND:  post = tkhr_pkg::POST_POUND_HOLD;
                            tkhr_pkg::KEY_TWO:    post = tkhr_pkg::POST_TWO_HOLD;
                            tkhr_pkg::KEY_DIGIT8: post = tkhr_pkg::POST_EIGHT_HOLD;
                            default:              post = tkhr_pkg::POST_NONE;
                        endcase
                    end
                    phase_next = phase_reg + 1'b1;
                end
            end
        end
        else
        begin
            last_key_next = tkhr_pkg::KEY_BLANK;
            hold_next     = '0;
        end

        if (wake_lock_next && post != tkhr_pkg::POST_CLOSE && post != tkhr_pkg::POST_POUND)
            post = tkhr_pkg::POST_NONE;

        res_next.posted_key  = post;
        res_next.current_key = cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_key_reg  <= tkhr_pkg::KEY_BLANK;
            hold_reg      <= '0;
            phase_reg     <= '0;
            wake_lock_reg <= 1'b0;
            quiet_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                last_key_reg  <= last_key_next;
                hold_reg      <= hold_next;
                phase_reg     <= phase_next;
                wake_lock_reg <= wake_lock_next;
                quiet_reg     <= quiet_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

[bench/tb_top.sv]
// testbench for the touch keypad hold/repeat decoder: directed table, then random key gestures
module tb_top;

    // touch channel of each key code, code 13 in the top nibble down to code 1 at the bottom
    localparam logic [4*tkhr_pkg::KEY_COUNT-1:0] CHAN_OF =
        {4'd12, 4'd1, 4'd8, 4'd9, 4'd2, 4'd3, 4'd10, 4'd4, 4'd5, 4'd11, 4'd7, 4'd6, 4'd0};

    localparam logic [tkhr_pkg::KEY_W-1:0] KEY_DIGIT0 = 4'd1;
    localparam int unsigned PLAN_ROWS = 18;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned BEATS_PER_PHASE = 135;

    typedef enum logic {ROW_SCAN, ROW_REGS} row_kind_t;

    typedef struct packed {
        row_kind_t       kind;
        tkhr_pkg::scan_t beat;
        logic [7:0]      reps;
        logic            typed;      // expected post typed into the row
        tkhr_pkg::post_t want;
        tkhr_pkg::cfg_t  regs;
    } plan_row_t;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // block inputs, all known from time zero
    logic                            scan_valid = 1'b0;
    tkhr_pkg::scan_t                 scan = '0;
    logic                            post_ready = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [tkhr_pkg::CFG_IDX_W-1:0]  cfg_index = tkhr_pkg::CFG_HOLD_DELAY;
    logic [tkhr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic            scan_ready;
    logic            post_valid;
    tkhr_pkg::post_t post;

    touch_keypad_hold_repeat_decoder_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_valid (scan_valid),
        .scan_ready (scan_ready),
        .scan       (scan),
        .post_valid (post_valid),
        .post_ready (post_ready),
        .post       (post),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // expected posts, oldest first
    tkhr_pkg::post_t posts_due [$];

    // side information travelling with the scan beat being offered
    logic            beat_typed = 1'b0;
    tkhr_pkg::post_t beat_want = '0;

    // decoder state and register copy kept by the predictor
    tkhr_pkg::cfg_t regs_now = '{tkhr_pkg::HOLD_DELAY_RESET, tkhr_pkg::HOLD_CAP_RESET,
                                 tkhr_pkg::WAKE_QUIET_RESET};
    logic [tkhr_pkg::KEY_W-1:0]   held_key = tkhr_pkg::KEY_BLANK;
    logic [tkhr_pkg::HOLD_W-1:0]  hold_ticks = '0;
    logic [tkhr_pkg::PHASE_W-1:0] rep_phase = '0;
    logic                         lock_on = 1'b0;
    logic [tkhr_pkg::QUIET_W-1:0] quiet_ticks = '0;

    // sender pacing
    logic        pace_gaps = 1'b1;
    int unsigned burst_left = 0;

    // run statistics
    int unsigned fails = 0;
    int unsigned beats_in = 0;
    int unsigned posts_out = 0;
    int unsigned hold_codes = 0;
    int unsigned settings_done = 0;

    plan_row_t plan [PLAN_ROWS];

    // one-hot channel mask for a key code, empty for no key
    function automatic logic [tkhr_pkg::CHANNELS-1:0] key_mask(
        input logic [tkhr_pkg::KEY_W-1:0] code);
        logic [tkhr_pkg::CHANNELS-1:0] m;
        m = '0;
        if (code != tkhr_pkg::KEY_BLANK && code <= tkhr_pkg::KEY_CLOSE)
            m[CHAN_OF[(code - 1) * 4 +: 4]] = 1'b1;
        return m;
    endfunction

    // one scan tick through the predictor: updates its state, returns the post it owes
    function automatic tkhr_pkg::post_t decode_tick(input tkhr_pkg::scan_t s);
        logic [tkhr_pkg::KEY_W-1:0]  cur;
        logic [tkhr_pkg::POST_W-1:0] code;
        tkhr_pkg::post_t             r;
        cur = tkhr_pkg::KEY_BLANK;
        code = tkhr_pkg::POST_NONE;
        if (s.wake_start)
        begin
            lock_on = 1'b1;
            quiet_ticks = '0;
        end
        if (s.key_bits == '0)
        begin
            if (quiet_ticks < regs_now.wake_quiet_ticks)
                quiet_ticks = quiet_ticks + 1'b1;
            else
                lock_on = 1'b0;
        end
        // the held key keeps priority while its channel stays down
        if ((s.key_bits & key_mask(held_key)) != '0)
            cur = held_key;
        else
            for (int c = 1; c <= tkhr_pkg::KEY_COUNT; c++)
                if (cur == tkhr_pkg::KEY_BLANK
                    && (s.key_bits & key_mask(tkhr_pkg::KEY_W'(c))) != '0)
                    cur = tkhr_pkg::KEY_W'(c);
        if (cur == tkhr_pkg::KEY_BLANK)
        begin
            held_key = tkhr_pkg::KEY_BLANK;
            hold_ticks = '0;
        end
        else if (cur != held_key)
        begin
            code = tkhr_pkg::POST_W'(cur);
            held_key = cur;
            hold_ticks = '0;
        end
        else
        begin
            if (hold_ticks < regs_now.hold_cap)
                hold_ticks = hold_ticks + 1'b1;
            if (hold_ticks > regs_now.hold_delay)
            begin
                if (rep_phase[1:0] == 2'b00)
                    case (cur)
                        tkhr_pkg::KEY_ASTER:  code = tkhr_pkg::POST_ASTER_HOLD;
                        tkhr_pkg::KEY_POUND:  code = tkhr_pkg::POST_POUND_HOLD;
                        tkhr_pkg::KEY_TWO:    code = tkhr_pkg::POST_TWO_HOLD;
                        tkhr_pkg::KEY_DIGIT8: code = tkhr_pkg::POST_EIGHT_HOLD;
                        default:              code = tkhr_pkg::POST_NONE;
                    endcase
                rep_phase = rep_phase + 1'b1;
            end
        end
        if (lock_on && code != tkhr_pkg::POST_CLOSE && code != tkhr_pkg::POST_POUND)
            code = tkhr_pkg::POST_NONE;
        r.posted_key = code;
        r.current_key = cur;
        return r;
    endfunction

    // table row builders
    function automatic plan_row_t scan_row(input logic [tkhr_pkg::CHANNELS-1:0] bits,
                                           input logic ws, input logic [7:0] reps);
        plan_row_t r;
        r = '0;
        r.kind = ROW_SCAN;
        r.beat = {bits, ws};
        r.reps = reps;
        return r;
    endfunction

    function automatic plan_row_t typed_row(input logic [tkhr_pkg::CHANNELS-1:0] bits,
                                            input logic ws,
                                            input logic [tkhr_pkg::POST_W-1:0] pk,
                                            input logic [tkhr_pkg::KEY_W-1:0] ck);
        plan_row_t r;
        r = scan_row(bits, ws, 8'd1);
        r.typed = 1'b1;
        r.want = {pk, ck};
        return r;
    endfunction

    function automatic plan_row_t regs_row(input logic [tkhr_pkg::HOLD_W-1:0] d,
                                           input logic [tkhr_pkg::HOLD_W-1:0] c,
                                           input logic [tkhr_pkg::QUIET_W-1:0] q);
        plan_row_t r;
        r = '0;
        r.kind = ROW_REGS;
        r.regs = '{d, c, q};
        return r;
    endfunction

    // offer one scan beat and hold it until taken; bursts and gaps when pacing is on
    task automatic send_beat(input tkhr_pkg::scan_t beat, input logic typed,
                             input tkhr_pkg::post_t want);
        if (pace_gaps && burst_left == 0)
        begin
            scan_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left != 0)
            burst_left--;
        scan <= beat;
        scan_valid <= 1'b1;
        beat_typed <= typed;
        beat_want <= want;
        do
            @(posedge clk);
        while (!scan_ready);
    endtask

    // stop offering and wait for every owed post, then let the pipeline settle
    task automatic drain_posts();
        int unsigned waited;
        waited = 0;
        scan_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (posts_due.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        if (posts_due.size() != 0)
        begin
            $error("%0d expected posts never arrived", posts_due.size());
            fails++;
            posts_due.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    // write all three registers on consecutive cycles, only called with nothing in flight
    task automatic set_regs(input tkhr_pkg::cfg_t r);
        regs_now = r;
        settings_done++;
        cfg_we <= 1'b1;
        cfg_index <= tkhr_pkg::CFG_HOLD_DELAY;
        cfg_data <= r.hold_delay;
        @(posedge clk);
        cfg_index <= tkhr_pkg::CFG_HOLD_CAP;
        cfg_data <= r.hold_cap;
        @(posedge clk);
        cfg_index <= tkhr_pkg::CFG_WAKE_QUIET;
        cfg_data <= tkhr_pkg::CFG_DATA_W'(r.wake_quiet_ticks);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // random key activity: mostly press-and-hold, idle runs and rolls, some raw noise
    task automatic play_gestures(input int unsigned count);
        int unsigned                   sent;
        int unsigned                   len;
        logic [tkhr_pkg::KEY_W-1:0]    k;
        logic [tkhr_pkg::KEY_W-1:0]    k2;
        logic [tkhr_pkg::CHANNELS-1:0] bits;
        sent = 0;
        while (sent < count)
        begin
            case ($urandom_range(0, 9)) inside
                [0:5]:
                begin
                    // press and hold, leaning on the keys that repeat
                    k = tkhr_pkg::KEY_W'($urandom_range(1, tkhr_pkg::KEY_COUNT));
                    if ($urandom_range(0, 1) != 0)
                        case ($urandom_range(0, 3))
                            0:       k = tkhr_pkg::KEY_ASTER;
                            1:       k = tkhr_pkg::KEY_POUND;
                            2:       k = tkhr_pkg::KEY_TWO;
                            default: k = tkhr_pkg::KEY_DIGIT8;
                        endcase
                    len = $urandom_range(1, 12);
                    if ($urandom_range(0, 3) == 0)
                        len += (regs_now.hold_delay < 140) ?
                               regs_now.hold_delay + $urandom_range(1, 12) : 20;
                    repeat (len)
                    begin
                        bits = key_mask(k);
                        // other channels brushing past while the key is held
                        if ($urandom_range(0, 5) == 0)
                            bits |= 16'($urandom) & 16'($urandom);
                        send_beat({bits, ($urandom_range(0, 23) == 0)}, 1'b0, '0);
                        sent++;
                    end
                end
                [6:7]:
                begin
                    // idle run around the quiet threshold
                    repeat ($urandom_range(1, regs_now.wake_quiet_ticks + 3))
                    begin
                        send_beat({16'h0000, ($urandom_range(0, 15) == 0)}, 1'b0, '0);
                        sent++;
                    end
                end
                8:
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        send_beat({16'($urandom), 1'($urandom)}, 1'b0, '0);
                        sent++;
                    end
                end
                default:
                begin
                    // roll from one key to another without a release
                    k = tkhr_pkg::KEY_W'($urandom_range(1, tkhr_pkg::KEY_COUNT));
                    k2 = tkhr_pkg::KEY_W'($urandom_range(1, tkhr_pkg::KEY_COUNT));
                    repeat ($urandom_range(1, 3))
                    begin
                        send_beat({key_mask(k), 1'b0}, 1'b0, '0);
                        sent++;
                    end
                    repeat ($urandom_range(1, 3))
                    begin
                        send_beat({key_mask(k) | key_mask(k2), 1'b0}, 1'b0, '0);
                        sent++;
                    end
                    repeat ($urandom_range(1, 3))
                    begin
                        send_beat({key_mask(k2), 1'b0}, 1'b0, '0);
                        sent++;
                    end
                end
            endcase
        end
    endtask

    // receiver back-pressure: free flow, light random, periodic and heavy stall windows
    logic [9:0] stall_tick = '0;

    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1'b1;
        case (stall_tick[9:8])
            2'd0:    post_ready <= 1'b1;
            2'd1:    post_ready <= ($urandom_range(0, 3) != 0);
            2'd2:    post_ready <= (stall_tick[4:2] != 3'd5);
            default: post_ready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    // scoreboard: predict on every scan beat taken, compare on every post beat taken
    always @(posedge clk)
    begin : scoreboard
        tkhr_pkg::post_t due;
        tkhr_pkg::post_t predicted;
        if (rst_n)
        begin
            if (post_valid && post_ready)
            begin
                posts_out++;
                if (post.posted_key >= tkhr_pkg::POST_ASTER_HOLD)
                    hold_codes++;
                if (posts_due.size() == 0)
                begin
                    $error("unexpected post beat: posted_key %0d current_key %0d",
                           post.posted_key, post.current_key);
                    fails++;
                end
                else
                begin
                    due = posts_due.pop_front();
                    if (post.posted_key !== due.posted_key)
                    begin
                        $error("posted_key: expected %0d, got %0d",
                               due.posted_key, post.posted_key);
                        fails++;
                    end
                    if (post.current_key !== due.current_key)
                    begin
                        $error("current_key: expected %0d, got %0d",
                               due.current_key, post.current_key);
                        fails++;
                    end
                end
            end
            if (scan_valid && scan_ready)
            begin
                // predictor always runs so its state tracks typed rows too
                predicted = decode_tick(scan);
                posts_due.push_back(beat_typed ? beat_want : predicted);
                beats_in++;
            end
        end
    end

    // stimulus sequence
    initial
    begin : stimulus
        tkhr_pkg::cfg_t r;
        plan = '{
            // straight out of reset, default registers
            typed_row(16'h0000, 1'b0, tkhr_pkg::POST_NONE, tkhr_pkg::KEY_BLANK),
            // every channel down: lowest key code wins
            typed_row(16'hFFFF, 1'b0, tkhr_pkg::POST_W'(KEY_DIGIT0), KEY_DIGIT0),
            // wake lock armed, door-close still posts
            typed_row(16'h1000, 1'b1, tkhr_pkg::POST_CLOSE, tkhr_pkg::KEY_CLOSE),
            typed_row(16'h0100, 1'b0, tkhr_pkg::POST_POUND, tkhr_pkg::KEY_POUND),
            // ordinary key swallowed by the wake lock
            typed_row(16'h0080, 1'b0, tkhr_pkg::POST_NONE, tkhr_pkg::KEY_TWO),
            // zero delay, widest cap, no quiet wait
            regs_row(9'd0, 9'd511, 5'd0),
            // one idle tick drops the wake lock
            typed_row(16'h0000, 1'b0, tkhr_pkg::POST_NONE, tkhr_pkg::KEY_BLANK),
            typed_row(16'h0002, 1'b0, tkhr_pkg::POST_W'(tkhr_pkg::KEY_ASTER),
                      tkhr_pkg::KEY_ASTER),
            // asterisk, two, eight and pound each held long enough for one hold code
            scan_row(16'h0002, 1'b0, 8'd1),
            scan_row(16'h0080, 1'b0, 8'd5),
            scan_row(16'h0004, 1'b0, 8'd5),
            scan_row(16'h0100, 1'b0, 8'd5),
            // cap dropped under the running hold count while pound stays down
            regs_row(9'd1, 9'd2, 5'd0),
            // pound hold comes round under the wake lock and is swallowed
            scan_row(16'h0100, 1'b1, 8'd1),
            scan_row(16'h0100, 1'b0, 8'd3),
            scan_row(16'h0000, 1'b0, 8'd1),
            // cap at zero below the largest delay: no hold codes at all
            regs_row(9'd511, 9'd0, 5'd31),
            scan_row(16'h0002, 1'b0, 8'd3)
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REGS)
            begin
                drain_posts();
                set_regs(plan[i].regs);
            end
            else
                repeat (plan[i].reps)
                    send_beat(plan[i].beat, plan[i].typed, plan[i].want);
        end

        // random phases, one register setting each, extremes included
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       r = '{9'd0, 9'd511, 5'd0};
                1:       r = '{9'd511, 9'd0, 5'd31};
                2:       r = '{9'd3, 9'd9, 5'd2};
                3:       r = '{9'd6, 9'd6, 5'd5};
                4:       r = '{tkhr_pkg::HOLD_DELAY_RESET, tkhr_pkg::HOLD_CAP_RESET,
                               tkhr_pkg::WAKE_QUIET_RESET};
                5:       r = '{9'd1, 9'd1, 5'd0};
                6:       r = '{9'($urandom_range(0, 12)), 9'($urandom_range(0, 30)),
                               5'($urandom_range(0, 31))};
                default: r = '{9'd2, 9'd511, 5'd31};
            endcase
            drain_posts();
            set_regs(r);
            // every third phase runs the sender flat out
            pace_gaps = (p % 3 != 1);
            play_gestures(BEATS_PER_PHASE);
        end

        drain_posts();
        repeat (8) @(posedge clk);

        $display("ran %0d scan beats and checked %0d posts (%0d hold codes)",
                 beats_in, posts_out, hold_codes);
        $display("over %0d register settings including both extremes of each field",
                 settings_done);
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog for a stuck handshake
    initial
    begin
        #4000000;
        $display("watchdog expired with %0d posts outstanding", posts_due.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
hdl/tkhr_pkg.sv
hdl/tkhr_in_reg.sv
hdl/tkhr_core.sv
hdl/touch_keypad_hold_repeat_decoder_top.sv
bench/tb_top.sv
